// ===== rtl/euler_to_quaternion_macros.svh =====
// assertion macros for the euler to quaternion converter
`ifndef EULER_TO_QUATERNION_MACROS_SVH
`define EULER_TO_QUATERNION_MACROS_SVH
`ifndef SYNTHESIS
`define E2Q_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define E2Q_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define E2Q_ASSERT_NOW(lbl, ante, cons, msg)
`define E2Q_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/e2q_pkg.sv =====
// shared types, constants and sine table function for the euler to quaternion converter
package e2q_pkg;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int MID_DEPTH        = 8;
    localparam int OUT_DEPTH        = 8;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] INV_PI_Q30  = 64'd341782638;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [14:0] Q14_ONE     = 15'd16384;

    typedef struct packed {
        logic signed [15:0] cr;
        logic signed [15:0] sr;
        logic signed [15:0] cp;
        logic signed [15:0] sp;
        logic signed [15:0] cy;
        logic signed [15:0] sy;
    } t_trig;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_quat;

    // taylor series sine of a q30 argument, rounded to q14
    function automatic logic [14:0] taylor_sine_q14(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] prod;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (int i = 0; i < 5; i++) begin
            prod = (x2 * t) >> 30;
            case (i)
                0:       t = Q30_ONE - prod / 64'd110;
                1:       t = Q30_ONE - prod / 64'd72;
                2:       t = Q30_ONE - prod / 64'd42;
                3:       t = Q30_ONE - prod / 64'd20;
                default: t = Q30_ONE - prod / 64'd6;
            endcase
        end
        s = (x * t) >> 30;
        s = (s + 64'd32768) >> 16;
        if (s > 64'(Q14_ONE)) begin
            s = 64'(Q14_ONE);
        end
        return s[14:0];
    endfunction

endpackage

// ===== rtl/e2q_fifo.sv =====
// small register queue with occupancy count
module e2q_fifo #(
    parameter int WIDTH = 96,
    parameter int DEPTH = e2q_pkg::MID_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic [WIDTH-1:0]         i_data,
    input  logic                     i_pop,
    output logic [WIDTH-1:0]         o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;
endmodule

// ===== rtl/e2q_front.sv =====
// front pipeline: half angle phase, quadrant fold and sine table lookup
module e2q_front #(
    parameter int SINE_TABLE_DEPTH = e2q_pkg::SINE_TABLE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic signed [15:0]  i_roll_angle,
    input  logic signed [15:0]  i_pitch_angle,
    input  logic signed [15:0]  i_yaw_angle,
    output logic                o_valid,
    output e2q_pkg::t_trig      o_trig,
    output logic [2:0]          o_inflight
);
    localparam int D  = SINE_TABLE_DEPTH;
    localparam int AW = $clog2(D+1);
    localparam int PW = $clog2(D) + 2;
    localparam logic [63:0] K = 64'(D) * e2q_pkg::INV_PI_Q30;
    localparam logic [20:0] K_LO = K[20:0];
    localparam logic [20:0] K_HI = K[41:21];
    localparam logic [PW-1:0] D1 = PW'(D);
    localparam logic [PW-1:0] D2 = PW'(2*D);
    localparam logic [PW-1:0] D3 = PW'(3*D);

    // constant quarter-wave table
    logic [14:0] w_sine [D+1];
    for (genvar k = 0; k <= D; k++) begin : g_tab
        localparam logic [63:0] ARG = (64'(k) * e2q_pkg::HALF_PI_Q30) / SINE_TABLE_DEPTH;
        localparam logic [14:0] VAL = e2q_pkg::taylor_sine_q14(ARG);
        assign w_sine[k] = VAL;
    end

    logic [5:0] r_vld;

    logic [15:0]   r_mag  [3];
    logic          r_neg1 [3];
    logic [36:0]   r_pplo [3];
    logic [36:0]   r_pphi [3];
    logic          r_neg2 [3];
    logic [PW-1:0] r_ph   [3];
    logic          r_neg3 [3];
    logic [AW-1:0] r_sadr [3];
    logic [AW-1:0] r_cadr [3];
    logic          r_sflp [3];
    logic          r_cflp [3];
    logic          r_neg4 [3];
    logic [14:0]   r_sv   [3];
    logic [14:0]   r_cv   [3];
    logic          r_sfl5 [3];
    logic          r_cfl5 [3];
    logic signed [15:0] r_sin [3];
    logic signed [15:0] r_cos [3];

    logic [15:0]   w_raw  [3];
    logic [63:0]   w_sum  [3];
    logic [PW-1:0] w_sx   [3];
    logic [PW-1:0] w_cx   [3];
    logic [AW-1:0] w_sadr [3];
    logic [AW-1:0] w_cadr [3];
    logic          w_sflp [3];
    logic          w_cflp [3];

    assign w_raw[0] = i_roll_angle;
    assign w_raw[1] = i_pitch_angle;
    assign w_raw[2] = i_yaw_angle;

    // fold a phase into a table address and a sign flip
    function automatic logic [AW+1-1:0] fold(input logic [PW-1:0] x);
        logic          q1, q2, q3;
        logic [PW-1:0] r;
        logic [AW-1:0] a;
        q1 = (x >= D1);
        q2 = (x >= D2);
        q3 = (x >= D3);
        r  = q3 ? x - D3 : (q2 ? x - D2 : (q1 ? x - D1 : x));
        a  = (q1 ^ q2 ^ q3) ? AW'(D1 - r) : r[AW-1:0];
        return {q2, a};
    endfunction

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_sum[a] = {6'b0, r_pphi[a], 21'b0} + 64'(r_pplo[a]) + (64'd1 << 42);
            w_sx[a]  = w_sum[a][43 +: PW];
            w_cx[a]  = r_ph[a] + D1;
            {w_sflp[a], w_sadr[a]} = fold(r_ph[a]);
            {w_cflp[a], w_cadr[a]} = fold(w_cx[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            // magnitude of the angle
            r_neg1[a] <= w_raw[a][15];
            r_mag[a]  <= w_raw[a][15] ? 16'(17'h10000 - 17'(w_raw[a])) : w_raw[a];
            // partial products of the phase scaling
            r_pplo[a] <= 37'(r_mag[a]) * 37'(K_LO);
            r_pphi[a] <= 37'(r_mag[a]) * 37'(K_HI);
            r_neg2[a] <= r_neg1[a];
            // rounded phase
            r_ph[a]   <= w_sx[a];
            r_neg3[a] <= r_neg2[a];
            // addresses
            r_sadr[a] <= w_sadr[a];
            r_cadr[a] <= w_cadr[a];
            r_sflp[a] <= w_sflp[a];
            r_cflp[a] <= w_cflp[a];
            r_neg4[a] <= r_neg3[a];
            // table read
            r_sv[a]   <= w_sine[r_sadr[a]];
            r_cv[a]   <= w_sine[r_cadr[a]];
            r_sfl5[a] <= r_sflp[a] ^ r_neg4[a];
            r_cfl5[a] <= r_cflp[a];
            // signed values
            r_sin[a]  <= r_sfl5[a] ? -$signed({1'b0, r_sv[a]}) : $signed({1'b0, r_sv[a]});
            r_cos[a]  <= r_cfl5[a] ? -$signed({1'b0, r_cv[a]}) : $signed({1'b0, r_cv[a]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    assign o_valid    = r_vld[5];
    assign o_inflight = 3'($countones(r_vld));
    assign o_trig     = '{cr: r_cos[0], sr: r_sin[0], cp: r_cos[1], sp: r_sin[1],
                          cy: r_cos[2], sy: r_sin[2]};
endmodule

// ===== rtl/e2q_back.sv =====
// back pipeline: triple products, sums, rounding and saturation
module e2q_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  e2q_pkg::t_trig  i_trig,
    output logic            o_valid,
    output e2q_pkg::t_quat  o_quat,
    output logic [2:0]      o_inflight
);
    logic [3:0] r_vld;

    logic signed [31:0] r_crcp, r_srsp, r_srcp, r_crsp;
    logic signed [15:0] r_cy, r_sy;
    logic signed [47:0] r_p [8];
    logic signed [48:0] r_s [4];
    logic signed [15:0] r_q [4];

    function automatic logic signed [15:0] round_sat(input logic signed [48:0] v);
        logic [48:0] mag;
        logic [48:0] rnd;
        logic [15:0] m;
        mag = v[48] ? 49'(-v) : 49'(v);
        rnd = (mag + (49'd1 << 27)) >> 28;
        m   = (rnd > 49'(e2q_pkg::Q14_ONE)) ? 16'(e2q_pkg::Q14_ONE) : rnd[15:0];
        return v[48] ? -$signed(m) : $signed(m);
    endfunction

    always_ff @(posedge i_clk) begin
        r_crcp <= i_trig.cr * i_trig.cp;
        r_srsp <= i_trig.sr * i_trig.sp;
        r_srcp <= i_trig.sr * i_trig.cp;
        r_crsp <= i_trig.cr * i_trig.sp;
        r_cy   <= i_trig.cy;
        r_sy   <= i_trig.sy;
        r_p[0] <= r_crcp * r_cy;
        r_p[1] <= r_srsp * r_sy;
        r_p[2] <= r_srcp * r_cy;
        r_p[3] <= r_crsp * r_sy;
        r_p[4] <= r_crsp * r_cy;
        r_p[5] <= r_srcp * r_sy;
        r_p[6] <= r_crcp * r_sy;
        r_p[7] <= r_srsp * r_cy;
        r_s[0] <= 49'(r_p[0]) + 49'(r_p[1]);
        r_s[1] <= 49'(r_p[2]) - 49'(r_p[3]);
        r_s[2] <= 49'(r_p[4]) + 49'(r_p[5]);
        r_s[3] <= 49'(r_p[6]) - 49'(r_p[7]);
        for (int c = 0; c < 4; c++) begin
            r_q[c] <= round_sat(r_s[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    assign o_valid    = r_vld[3];
    assign o_inflight = 3'($countones(r_vld));
    assign o_quat     = '{w: r_q[0], x: r_q[1], y: r_q[2], z: r_q[3]};
endmodule

// ===== rtl/euler_to_quaternion.sv =====
// euler angles (z-y-x) to unit quaternion converter, top level
// path: from push through the front pipeline, middle queue, back pipeline and result queue to the result ports
// throughput: one word per cycle; front and back pipelines never stall, credits on the
// middle and result queues hold back push and issue when the queues would overflow
// reset: synchronous active-low clears all valid bits, queue pointers and counts
`include "euler_to_quaternion_macros.svh"
module euler_to_quaternion #(
    parameter int SINE_TABLE_DEPTH = e2q_pkg::SINE_TABLE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] i_roll_angle,
    input  logic signed [15:0] i_pitch_angle,
    input  logic signed [15:0] i_yaw_angle,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] o_quat_w,
    output logic signed [15:0] o_quat_x,
    output logic signed [15:0] o_quat_y,
    output logic signed [15:0] o_quat_z
);
    localparam int MCW = $clog2(e2q_pkg::MID_DEPTH+1);
    localparam int OCW = $clog2(e2q_pkg::OUT_DEPTH+1);
    localparam int TW  = $bits(e2q_pkg::t_trig);
    localparam int QW  = $bits(e2q_pkg::t_quat);

    // front: phase and table lookup
    logic            w_in_acc;
    logic            w_f_vld;
    e2q_pkg::t_trig  w_f_trig;
    logic [2:0]      w_f_infl;

    // middle queue between front and back
    logic [TW-1:0]   w_m_data;
    logic [MCW-1:0]  w_m_count;
    logic            w_issue;

    // back: products and rounding
    logic            w_b_vld;
    e2q_pkg::t_quat  w_b_quat;
    logic [2:0]      w_b_infl;

    // result queue
    logic [QW-1:0]   w_o_data;
    logic [OCW-1:0]  w_o_count;
    e2q_pkg::t_quat  w_res;
    logic            w_out_acc;

    // a word is only let in when the middle queue holds room for everything in flight
    assign full     = (5'(w_m_count) + 5'(w_f_infl)) >= 5'(e2q_pkg::MID_DEPTH);
    assign w_in_acc = push && !full;

    e2q_front #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_in_acc),
        .i_roll_angle  (i_roll_angle),
        .i_pitch_angle (i_pitch_angle),
        .i_yaw_angle   (i_yaw_angle),
        .o_valid       (w_f_vld),
        .o_trig        (w_f_trig),
        .o_inflight    (w_f_infl)
    );

    e2q_fifo #(
        .WIDTH (TW),
        .DEPTH (e2q_pkg::MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_vld),
        .i_data  (w_f_trig),
        .i_pop   (w_issue),
        .o_data  (w_m_data),
        .o_count (w_m_count)
    );

    // back issues only when the result queue can take everything it has in flight
    assign w_issue = (w_m_count != '0) &&
                     ((5'(w_o_count) + 5'(w_b_infl)) < 5'(e2q_pkg::OUT_DEPTH));

    e2q_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_issue),
        .i_trig     (e2q_pkg::t_trig'(w_m_data)),
        .o_valid    (w_b_vld),
        .o_quat     (w_b_quat),
        .o_inflight (w_b_infl)
    );

    assign empty     = (w_o_count == '0);
    assign w_out_acc = pop && !empty;

    e2q_fifo #(
        .WIDTH (QW),
        .DEPTH (e2q_pkg::OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_b_vld),
        .i_data  (w_b_quat),
        .i_pop   (w_out_acc),
        .o_data  (w_o_data),
        .o_count (w_o_count)
    );

    assign w_res    = e2q_pkg::t_quat'(w_o_data);
    assign o_quat_w = w_res.w;
    assign o_quat_x = w_res.x;
    assign o_quat_y = w_res.y;
    assign o_quat_z = w_res.z;

    // middle queue credit never overdrawn
    `E2Q_ASSERT_NOW(a_mid_credit, 1'b1, (5'(w_m_count) + 5'(w_f_infl)) <= 5'(e2q_pkg::MID_DEPTH), "middle queue overrun")
    // result queue credit never overdrawn
    `E2Q_ASSERT_NOW(a_out_credit, 1'b1, (5'(w_o_count) + 5'(w_b_infl)) <= 5'(e2q_pkg::OUT_DEPTH), "result queue overrun")
    // an accepted word always raises the front occupancy next cycle
    `E2Q_ASSERT_NEXT(a_front_take, w_in_acc, w_f_infl != 3'd0, "accepted word lost in front")
    // shown scalar stays within plus or minus one
    `E2Q_ASSERT_NOW(a_w_range, !empty, ($signed(o_quat_w) <= 16'sd16384) && ($signed(o_quat_w) >= -16'sd16384), "quat_w out of range")
endmodule
